FILE: rtl/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types, constants and helpers for the multilevel ready queue.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int Levels   = 4;
  localparam int MaxTasks = 16;
  localparam int PidW     = 4;
  localparam int LvlW     = 2;
  localparam int LinkW    = PidW + 1;
  localparam int StateW   = 2;
  localparam int ActW     = 3;
  localparam int CfgIdxW  = 1;

  typedef logic [PidW-1:0]   pid_t;
  typedef logic [LvlW-1:0]   lvl_t;
  typedef logic [LinkW-1:0]  link_t;
  typedef logic [StateW-1:0] tstate_t;

  localparam link_t   NilLink  = LinkW'(MaxTasks);
  localparam tstate_t TsNew    = 2'd0;
  localparam tstate_t TsReady  = 2'd1;
  localparam tstate_t TsMemBlk = 2'd2;

  typedef enum logic [ActW-1:0] {
    ActAdd       = 3'd0,
    ActPop       = 3'd1,
    ActRemove    = 3'd2,
    ActFindReady = 3'd3,
    ActFindMem   = 3'd4,
    ActSetState  = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimerPid = 1'b0,
    CfgUartPid  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StAddLink,
    StPopUpd,
    StWalk,
    StCheck,
    StDone
  } state_e;

  typedef struct packed {
    logic    we_next;
    logic    we_state;
    pid_t    waddr;
    link_t   wnext;
    tstate_t wstate;
    pid_t    raddr;
  } mem_req_t;

  typedef struct packed {
    link_t   rnext;
    tstate_t rstate;
  } mem_rsp_t;

  typedef struct packed {
    logic    found;
    pid_t    pid;
    tstate_t st;
  } result_t;

  function automatic logic link_ok(link_t l);
    return l < NilLink;
  endfunction

endpackage

FILE: rtl/mlrq_mem.sv
// ----------------------------------------------------------------------------
// mlrq_mem
// Per-pid entry store: next link and task state, registered read.
// ----------------------------------------------------------------------------
module mlrq_mem (
  input  logic              clk_i,
  input  mlrq_pkg::mem_req_t req_i,
  output mlrq_pkg::mem_rsp_t rsp_o
);
  import mlrq_pkg::*;

  link_t   next_mem  [MaxTasks];
  tstate_t state_mem [MaxTasks];

  always_ff @(posedge clk_i) begin
    if (req_i.we_next) begin
      next_mem[req_i.waddr] <= req_i.wnext;
    end
    if (req_i.we_state) begin
      state_mem[req_i.waddr] <= req_i.wstate;
    end
    rsp_o.rnext  <= next_mem[req_i.raddr];
    rsp_o.rstate <= state_mem[req_i.raddr];
  end

endmodule

FILE: rtl/mlrq_ctrl.sv
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Sequencer: level heads and tails, queued bits, list walk and unlink.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  mlrq_pkg::pid_t     pid_i,
  input  mlrq_pkg::lvl_t     level_i,
  input  mlrq_pkg::tstate_t  task_state_i,
  input  mlrq_pkg::pid_t     timer_pid_i,
  input  mlrq_pkg::pid_t     uart_pid_i,
  input  logic               out_free_i,
  output logic               done_o,
  output mlrq_pkg::result_t  res_o,
  output mlrq_pkg::mem_req_t mem_req_o,
  input  mlrq_pkg::mem_rsp_t mem_rsp_i
);
  import mlrq_pkg::*;

  state_e  state_q, state_d;
  action_e act_q, act_d;
  pid_t    pid_q, pid_d;
  lvl_t    lvl_q, lvl_d;
  tstate_t st_q, st_d;
  link_t   head_q [Levels];
  link_t   head_d [Levels];
  link_t   tail_q [Levels];
  link_t   tail_d [Levels];
  logic [MaxTasks-1:0] queued_q, queued_d;
  link_t   cur_q, cur_d;
  link_t   prev_q, prev_d;
  lvl_t    lvc_q, lvc_d;
  result_t res_q, res_d;

  logic  lvl_ok, add_ok, add_append, queued_pid, cur_ok, last_lvl, match, is_rm;
  link_t head_lv, tail_lv, new_head;
  pid_t  cur_pid;
  logic  ht_ok;

  assign head_lv    = head_q[lvl_q];
  assign tail_lv    = tail_q[lvl_q];
  assign lvl_ok     = ({1'b0, lvl_q} < (LvlW+1)'(Levels));
  assign queued_pid = queued_q[pid_q];
  assign add_ok     = lvl_ok && (pid_q != '0) && (pid_q != timer_pid_i)
                      && (pid_q != uart_pid_i) && !queued_pid;
  assign add_append = link_ok(head_lv) && link_ok(tail_lv);
  assign cur_ok     = link_ok(cur_q);
  assign cur_pid    = cur_q[PidW-1:0];
  assign last_lvl   = (lvc_q == LvlW'(Levels - 1));
  assign is_rm      = (act_q == ActRemove);
  assign new_head   = link_ok(prev_q) ? head_q[lvc_q] : mem_rsp_i.rnext;

  always_comb begin
    if (is_rm) begin
      match = (cur_pid == pid_q);
    end else if (act_q == ActFindMem) begin
      match = (mem_rsp_i.rstate == TsMemBlk);
    end else begin
      match = (mem_rsp_i.rstate == TsNew) || (mem_rsp_i.rstate == TsReady);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDecode;
      end
      StDecode: begin
        unique case (act_q)
          ActAdd:       state_d = (add_ok && add_append) ? StAddLink : StDone;
          ActPop:       state_d = (lvl_ok && link_ok(head_lv)) ? StPopUpd : StDone;
          ActRemove:    state_d = queued_pid ? StWalk : StDone;
          ActFindReady: state_d = StWalk;
          ActFindMem:   state_d = StWalk;
          default:      state_d = StDone;
        endcase
      end
      StAddLink: state_d = StDone;
      StPopUpd:  state_d = StDone;
      StWalk: begin
        if (cur_ok) state_d = StCheck;
        else if (last_lvl) state_d = StDone;
      end
      StCheck: begin
        state_d = match ? StDone : StWalk;
      end
      StDone: begin
        if (out_free_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_d     = act_q;
    pid_d     = pid_q;
    lvl_d     = lvl_q;
    st_d      = st_q;
    head_d    = head_q;
    tail_d    = tail_q;
    queued_d  = queued_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    lvc_d     = lvc_q;
    res_d     = res_q;
    done_o    = 1'b0;
    mem_req_o = '0;
    mem_req_o.raddr = cur_pid;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          act_d = action_e'(action_i);
          pid_d = pid_i;
          lvl_d = level_i;
          st_d  = task_state_i;
          res_d = '0;
        end
      end
      StDecode: begin
        unique case (act_q)
          ActAdd: begin
            if (add_ok) begin
              mem_req_o.we_next  = 1'b1;
              mem_req_o.we_state = 1'b1;
              mem_req_o.waddr    = pid_q;
              mem_req_o.wnext    = NilLink;
              mem_req_o.wstate   = st_q;
              queued_d[pid_q]    = 1'b1;
              tail_d[lvl_q]      = {1'b0, pid_q};
              prev_d             = tail_lv;
              if (!add_append) head_d[lvl_q] = {1'b0, pid_q};
              res_d.found = 1'b1;
            end
          end
          ActPop: begin
            mem_req_o.raddr = head_lv[PidW-1:0];
            cur_d           = head_lv;
          end
          ActRemove, ActFindReady, ActFindMem: begin
            lvc_d  = '0;
            cur_d  = head_q[0];
            prev_d = NilLink;
          end
          ActSetState: begin
            if (queued_pid) begin
              mem_req_o.we_state = 1'b1;
              mem_req_o.waddr    = pid_q;
              mem_req_o.wstate   = st_q;
              res_d.found        = 1'b1;
            end
          end
          default: ;
        endcase
      end
      StAddLink: begin
        mem_req_o.we_next = 1'b1;
        mem_req_o.waddr   = prev_q[PidW-1:0];
        mem_req_o.wnext   = {1'b0, pid_q};
      end
      StPopUpd: begin
        head_d[lvl_q] = mem_rsp_i.rnext;
        if (!link_ok(mem_rsp_i.rnext)) begin
          head_d[lvl_q] = NilLink;
          tail_d[lvl_q] = NilLink;
        end
        queued_d[cur_pid] = 1'b0;
        res_d = '{found: 1'b1, pid: cur_pid, st: mem_rsp_i.rstate};
      end
      StWalk: begin
        if (!cur_ok && !last_lvl) begin
          lvc_d  = lvc_q + 1'b1;
          cur_d  = head_q[lvc_q + 1'b1];
          prev_d = NilLink;
        end
      end
      StCheck: begin
        if (match) begin
          res_d = '{found: 1'b1, pid: cur_pid, st: mem_rsp_i.rstate};
          if (is_rm) begin
            if (link_ok(prev_q)) begin
              mem_req_o.we_next = 1'b1;
              mem_req_o.waddr   = prev_q[PidW-1:0];
              mem_req_o.wnext   = mem_rsp_i.rnext;
            end else begin
              head_d[lvc_q] = mem_rsp_i.rnext;
            end
            if (tail_q[lvc_q] == cur_q) tail_d[lvc_q] = prev_q;
            if (!link_ok(new_head)) begin
              head_d[lvc_q] = NilLink;
              tail_d[lvc_q] = NilLink;
            end
            queued_d[cur_pid] = 1'b0;
          end
        end else begin
          prev_d = cur_q;
          cur_d  = mem_rsp_i.rnext;
        end
      end
      StDone: begin
        done_o = out_free_i;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      queued_q <= '0;
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= NilLink;
        tail_q[i] <= NilLink;
      end
    end else begin
      state_q  <= state_d;
      queued_q <= queued_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    pid_q  <= pid_d;
    lvl_q  <= lvl_d;
    st_q   <= st_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    lvc_q  <= lvc_d;
    res_q  <= res_d;
  end

  // head and tail are empty together on every level
  always_comb begin
    ht_ok = 1'b1;
    for (int i = 0; i < Levels; i++) begin
      if (link_ok(head_q[i]) != link_ok(tail_q[i])) ht_ok = 1'b0;
    end
  end

  a_ht_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni) ht_ok)
    else $error("level head and tail disagree on empty");
  a_pid0_never_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !queued_q[0])
    else $error("pid 0 marked queued");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !(mem_req_o.we_next || mem_req_o.we_state))
    else $error("entry store written while idle");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == StIdle))
    else $error("sequencer did not return to idle after done");

endmodule

FILE: rtl/multilevel_ready_queue.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue
// Scheduler ready queue: one linked FIFO of pids per priority level.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | action, pid, level, task_state
//   out     | output    | out_valid_o / out_stall_i| found, result_pid, result_state
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_idx_i, cfg_data_i
//
// set state, unused actions and an add that starts a level or is refused go
// from decode straight to done; pop and an add appended behind a tail also
// pass the pop update or link state; remove and find visit each linked entry
// in a walk and a check state (registered entry store read), level by level.
// one word in flight; in_stall_o is high while a word is being worked on.
// a finished word waits in the sequencer while the output register is stalled.
// reset clears queued bits and level heads and tails; no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_ready_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               action_i,
  input  mlrq_pkg::pid_t           pid_i,
  input  mlrq_pkg::lvl_t           level_i,
  input  mlrq_pkg::tstate_t        task_state_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output mlrq_pkg::pid_t           result_pid_o,
  output mlrq_pkg::tstate_t        result_state_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [0:0]               cfg_idx_i,
  input  mlrq_pkg::pid_t           cfg_data_i
);
  import mlrq_pkg::*;

  pid_t     timer_pid_q, uart_pid_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;
  logic     out_free, ctl_done;
  result_t  ctl_res;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_pid_q <= PidW'(14);
      uart_pid_q  <= PidW'(15);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTimerPid: timer_pid_q <= cfg_data_i;
        CfgUartPid:  uart_pid_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlrq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .busy_o       (in_stall_o),
    .action_i     (action_i),
    .pid_i        (pid_i),
    .level_i      (level_i),
    .task_state_i (task_state_i),
    .timer_pid_i  (timer_pid_q),
    .uart_pid_i   (uart_pid_q),
    .out_free_i   (out_free),
    .done_o       (ctl_done),
    .res_o        (ctl_res),
    .mem_req_o    (mem_req),
    .mem_rsp_i    (mem_rsp)
  );

  mlrq_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_done) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_done) out_q <= ctl_res;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_q.found;
  assign result_pid_o   = out_q.pid;
  assign result_state_o = out_q.st;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multilevel ready queue. A queue of scheduler
// words, directed first and then random, feeds a clocked driver; a clocked
// monitor compares every result word with a cycle-free scheduler model kept
// here. Both sides idle and stall at random, the receiver once holds off
// long enough to back up the input, and the interrupt pids are reprogrammed
// between phases.
// ----------------------------------------------------------------------------
module testbench;
  import mlrq_pkg::*;

  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;

  typedef struct {
    logic [2:0] action;
    pid_t       pid;
    lvl_t       level;
    tstate_t    st;
  } sched_word_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i = '0;
  pid_t       pid_i = '0;
  lvl_t       level_i = '0;
  tstate_t    task_state_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       found_o;
  pid_t       result_pid_o;
  tstate_t    result_state_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [0:0] cfg_idx_i = '0;
  pid_t       cfg_data_i = '0;

  logic hold_out = 1'b0;

  sched_word_t pending_words[$];
  result_t     due_results[$];
  sched_word_t cur_word;
  logic        on_bus;
  int unsigned tx_gap;
  int unsigned rx_wait;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned errors = 0;

  // scheduler model state
  link_t   lvl_head  [Levels];
  link_t   lvl_tail  [Levels];
  link_t   pid_next  [MaxTasks];
  tstate_t pid_state [MaxTasks];
  logic    pid_queued[MaxTasks];
  pid_t    timer_pid;
  pid_t    uart_pid;

  multilevel_ready_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pid_i         (pid_i),
    .level_i       (level_i),
    .task_state_i  (task_state_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .result_pid_o  (result_pid_o),
    .result_state_o(result_state_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic result_t apply_sched_word(sched_word_t w);
    result_t r;
    link_t   cur;
    link_t   prev;
    logic    hit;
    logic    match;
    int      lv;
    int      n;
    r   = '0;
    hit = 1'b0;
    case (w.action)
      ActAdd: begin
        if (w.pid != '0 && w.pid != timer_pid && w.pid != uart_pid
            && !pid_queued[w.pid]) begin
          pid_next[w.pid]   = NilLink;
          pid_state[w.pid]  = w.st;
          pid_queued[w.pid] = 1'b1;
          if (lvl_head[w.level] >= NilLink || lvl_tail[w.level] >= NilLink) begin
            lvl_head[w.level] = {1'b0, w.pid};
          end else begin
            pid_next[lvl_tail[w.level][PidW-1:0]] = {1'b0, w.pid};
          end
          lvl_tail[w.level] = {1'b0, w.pid};
          r.found = 1'b1;
        end
      end
      ActPop: begin
        cur = lvl_head[w.level];
        if (cur < NilLink) begin
          lvl_head[w.level] = pid_next[cur[PidW-1:0]];
          if (lvl_head[w.level] >= NilLink) begin
            lvl_head[w.level] = NilLink;
            lvl_tail[w.level] = NilLink;
          end
          pid_queued[cur[PidW-1:0]] = 1'b0;
          r.found = 1'b1;
          r.pid   = cur[PidW-1:0];
          r.st    = pid_state[cur[PidW-1:0]];
        end
      end
      ActRemove: begin
        if (pid_queued[w.pid]) begin
          for (lv = 0; lv < Levels && !hit; lv++) begin
            prev = NilLink;
            cur  = lvl_head[lv];
            for (n = 0; n < MaxTasks && cur < NilLink && !hit; n++) begin
              if (cur == {1'b0, w.pid}) begin
                if (prev == NilLink) lvl_head[lv] = pid_next[cur[PidW-1:0]];
                else pid_next[prev[PidW-1:0]] = pid_next[cur[PidW-1:0]];
                if (lvl_tail[lv] == cur) lvl_tail[lv] = prev;
                if (lvl_head[lv] >= NilLink) begin
                  lvl_head[lv] = NilLink;
                  lvl_tail[lv] = NilLink;
                end
                pid_queued[cur[PidW-1:0]] = 1'b0;
                hit = 1'b1;
              end else begin
                prev = cur;
                cur  = pid_next[cur[PidW-1:0]];
              end
            end
          end
          if (hit) begin
            r.found = 1'b1;
            r.pid   = w.pid;
            r.st    = pid_state[w.pid];
          end
        end
      end
      ActFindReady, ActFindMem: begin
        for (lv = 0; lv < Levels && !hit; lv++) begin
          cur = lvl_head[lv];
          for (n = 0; n < MaxTasks && cur < NilLink && !hit; n++) begin
            if (w.action == ActFindMem) begin
              match = (pid_state[cur[PidW-1:0]] == TsMemBlk);
            end else begin
              match = (pid_state[cur[PidW-1:0]] == TsNew ||
                       pid_state[cur[PidW-1:0]] == TsReady);
            end
            if (match) begin
              hit     = 1'b1;
              r.found = 1'b1;
              r.pid   = cur[PidW-1:0];
              r.st    = pid_state[cur[PidW-1:0]];
            end else begin
              cur = pid_next[cur[PidW-1:0]];
            end
          end
        end
      end
      ActSetState: begin
        if (pid_queued[w.pid]) begin
          pid_state[w.pid] = w.st;
          r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic sched_word_t mk_word(logic [2:0] act, pid_t p, lvl_t lv, tstate_t s);
    sched_word_t w;
    w.action = act;
    w.pid    = p;
    w.level  = lv;
    w.st     = s;
    return w;
  endfunction

  function automatic sched_word_t random_word();
    sched_word_t w;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    w.pid   = PidW'($urandom_range(0, 15));
    w.level = LvlW'($urandom_range(0, 3));
    w.st    = StateW'($urandom_range(0, 3));
    if (pick < 36) w.action = ActAdd;
    else if (pick < 50) w.action = ActPop;
    else if (pick < 64) w.action = ActRemove;
    else if (pick < 74) w.action = ActFindReady;
    else if (pick < 84) w.action = ActFindMem;
    else if (pick < 97) w.action = ActSetState;
    else if (pick < 99) w.action = ActSpare6;
    else w.action = ActSpare7;
    return w;
  endfunction

  task automatic queue_random(int count);
    repeat (count) pending_words.push_back(random_word());
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || on_bus || due_results.size() != 0) @(posedge clk_i);
    repeat (48) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, pid_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTimerPid) timer_pid = val;
    else uart_pid = val;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      action_i     <= '0;
      pid_i        <= '0;
      level_i      <= '0;
      task_state_i <= '0;
      on_bus = 1'b0;
      tx_gap = 0;
      for (int i = 0; i < Levels; i++) begin
        lvl_head[i] = NilLink;
        lvl_tail[i] = NilLink;
      end
      for (int i = 0; i < MaxTasks; i++) begin
        pid_next[i]   = NilLink;
        pid_state[i]  = TsNew;
        pid_queued[i] = 1'b0;
      end
      timer_pid = 4'd14;
      uart_pid  = 4'd15;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(apply_sched_word(cur_word));
        n_accepted++;
        on_bus = 1'b0;
        tx_gap = ((n_accepted / 64) % 4 == 2) ? 0 : $urandom_range(0, 4);
      end else if (!on_bus && tx_gap > 0) begin
        tx_gap--;
      end
      if (!on_bus && tx_gap == 0 && pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        on_bus   = 1'b1;
      end
      in_valid_i   <= on_bus;
      action_i     <= cur_word.action;
      pid_i        <= cur_word.pid;
      level_i      <= cur_word.level;
      task_state_i <= cur_word.st;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: found=%0d pid=%0d state=%0d",
                     found_o, result_pid_o, result_state_o);
        end else begin
          want = due_results.pop_front();
          if (found_o !== want.found || result_pid_o !== want.pid ||
              result_state_o !== want.st) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected found=%0d pid=%0d state=%0d, ",
                        "got found=%0d pid=%0d state=%0d"},
                       want.found, want.pid, want.st,
                       found_o, result_pid_o, result_state_o);
          end
        end
        n_results++;
        rx_wait = ((n_results / 50) % 5 == 1) ? 0 : $urandom_range(0, 4);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= hold_out || (rx_wait != 0);
    end
  end

  // long receiver hold-off so the input backs up
  initial begin
    wait (n_accepted >= 150);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    pending_words.push_back(mk_word(ActFindReady, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActFindMem, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActPop, 4'd0, 2'd3, 2'd0));
    pending_words.push_back(mk_word(ActRemove, 4'd5, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActSetState, 4'd5, 2'd0, TsMemBlk));
    pending_words.push_back(mk_word(ActAdd, 4'd0, 2'd0, TsNew));
    pending_words.push_back(mk_word(ActAdd, 4'd14, 2'd1, TsReady));
    pending_words.push_back(mk_word(ActAdd, 4'd15, 2'd2, TsReady));
    pending_words.push_back(mk_word(ActAdd, 4'd1, 2'd0, 2'd3));
    pending_words.push_back(mk_word(ActAdd, 4'd2, 2'd0, TsMemBlk));
    pending_words.push_back(mk_word(ActAdd, 4'd3, 2'd3, TsReady));
    pending_words.push_back(mk_word(ActAdd, 4'd13, 2'd3, TsNew));
    pending_words.push_back(mk_word(ActAdd, 4'd1, 2'd2, TsNew));
    pending_words.push_back(mk_word(ActFindReady, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActFindMem, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActSetState, 4'd1, 2'd0, TsReady));
    pending_words.push_back(mk_word(ActFindReady, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActRemove, 4'd2, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActRemove, 4'd13, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActRemove, 4'd1, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActPop, 4'd0, 2'd3, 2'd0));
    pending_words.push_back(mk_word(ActPop, 4'd0, 2'd0, 2'd0));
    pending_words.push_back(mk_word(ActSpare6, 4'd15, 2'd3, 2'd3));
    pending_words.push_back(mk_word(ActSpare7, 4'd15, 2'd3, 2'd3));
    pending_words.push_back(mk_word(ActAdd, 4'd12, 2'd2, TsMemBlk));
    queue_random(300);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    write_reg(CfgTimerPid, 4'd0);
    write_reg(CfgUartPid, 4'd0);
    queue_random(200);
    settle();

    write_reg(CfgTimerPid, 4'd15);
    write_reg(CfgUartPid, 4'd15);
    queue_random(200);
    settle();

    write_reg(CfgTimerPid, 4'd3);
    write_reg(CfgUartPid, 4'd9);
    queue_random(200);
    settle();

    write_reg(CfgTimerPid, PidW'($urandom_range(0, 15)));
    write_reg(CfgUartPid, PidW'($urandom_range(0, 15)));
    queue_random(225);
    settle();

    errors += due_results.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
